### sv/rgbm_pkg.sv
// Shared types and constants for the RGB 3x3 dual-kernel magnitude unit.
package rgbm_pkg;

  localparam int MAX_WIDTH_D  = 2048;
  localparam int MAX_HEIGHT_D = 2048;
  localparam int CHANNELS_D   = 3;
  localparam int NCH          = 3;   // channels carried on the ports
  localparam int PIX_W        = 8;
  localparam int COORD_W      = 11;
  localparam int REG_W        = 12;
  localparam int SUM_W        = 16;
  localparam int ROOT_W       = 8;
  localparam int Q_DEPTH      = 4;

  localparam logic [REG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [SUM_W-1:0] SAT_LIMIT  = 16'd65025;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] sum;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic                      last;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### sv/rgbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/rgbm_front.sv
// Front end: position counters, line stores, 3x3 window, kernel and squared sum.
module rgbm_front #(
  parameter int MAX_WIDTH  = rgbm_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = rgbm_pkg::MAX_HEIGHT_D,
  parameter int CHANNELS   = rgbm_pkg::CHANNELS_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  rgbm_pkg::pix_t              in_px,
  input  logic                        in_frame_start,
  output logic                        in_stall,
  input  logic [rgbm_pkg::REG_W-1:0]  cfg_width,
  input  logic [rgbm_pkg::REG_W-1:0]  cfg_height,
  input  rgbm_pkg::qstat_t            q_stat,
  output logic                        q_push,
  output rgbm_pkg::qent_t             q_data
);
  import rgbm_pkg::*;

  localparam int ACT = (CHANNELS < NCH) ? CHANNELS : NCH;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = (WW > REG_W) ? WW : REG_W;
  localparam int YW  = (HW > REG_W) ? HW : REG_W;
  localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW = (RW > COORD_W) ? RW : COORD_W;
  localparam int LW  = ACT * PIX_W;

  typedef logic [ACT-1:0][PIX_W-1:0] apix_t;

  // effective frame size
  logic [XW-1:0] w_x;
  logic [YW-1:0] h_x;
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;

  assign w_x = XW'(cfg_width);
  assign h_x = YW'(cfg_height);
  assign w_c = (w_x < XW'(3)) ? WW'(3) : (w_x > XW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_x);
  assign h_c = (h_x < YW'(3)) ? HW'(3) : (h_x > YW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_x);

  logic adv, acc;
  logic h_v_r;

  assign adv      = !(h_v_r && q_stat.full);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // position
  logic [CW-1:0] col_r, col_cur;
  logic [RW-1:0] row_r, row_cur;
  logic          col_end, row_end, produce, last;
  apix_t         px_in;

  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign col_end = (WW'(col_cur) + WW'(1)) >= w_c;
  assign row_end = (HW'(row_cur) + HW'(1)) >= h_c;
  assign produce = (col_cur >= CW'(2)) && (row_cur >= RW'(2)) &&
                   (WW'(col_cur) < w_c) && (HW'(row_cur) < h_c);
  assign last    = (WW'(col_cur) == w_c - WW'(1)) && (HW'(row_cur) == h_c - HW'(1));

  for (genvar k = 0; k < ACT; k++) begin : g_pin
    assign px_in[k] = in_px[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_cur + RW'(1);
      end else begin
        col_r <= col_cur + CW'(1);
        row_r <= row_cur;
      end
    end
  end

  // P stage: line store read in flight
  logic               p_v_r, p_prod_r, p_last_r, hit_r;
  logic [CW-1:0]      p_col_r;
  logic [COORD_W-1:0] p_ccol_r, p_crow_r;
  apix_t              p_px_r, byp_up_r, byp_mid_r;
  logic [LW-1:0]      ram_up, ram_mid;
  apix_t              up_eff, mid_eff;
  logic               wr_en;

  assign up_eff  = hit_r ? byp_up_r  : apix_t'(ram_up);
  assign mid_eff = hit_r ? byp_mid_r : apix_t'(ram_mid);
  assign wr_en   = adv && p_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_prod_r  <= produce;
      p_last_r  <= last;
      p_col_r   <= col_cur;
      p_ccol_r  <= COORD_W'(CXW'(col_cur) - CXW'(1));
      p_crow_r  <= COORD_W'(RXW'(row_cur) - RXW'(1));
      p_px_r    <= px_in;
      // same column written this cycle: forward it
      hit_r     <= p_v_r && (p_col_r == col_cur);
      byp_up_r  <= mid_eff;
      byp_mid_r <= p_px_r;
    end
  end

  rgbm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p_col_r),
    .wdata (LW'(mid_eff)),
    .re    (acc),
    .raddr (col_cur),
    .rdata (ram_up)
  );

  rgbm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p_col_r),
    .wdata (LW'(p_px_r)),
    .re    (acc),
    .raddr (col_cur),
    .rdata (ram_mid)
  );

  // window [row][col]
  logic [2:0][2:0][ACT-1:0][PIX_W-1:0] win_r;
  logic [ACT-1:0][11:0]                hh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (wr_en) begin
      win_r[0] <= {up_eff,  win_r[0][2], win_r[0][1]};
      win_r[1] <= {mid_eff, win_r[1][2], win_r[1][1]};
      win_r[2] <= {p_px_r,  win_r[2][2], win_r[2][1]};
    end
  end

  // kernel on the shifted window; both kernels give the same value here
  for (genvar k = 0; k < ACT; k++) begin : g_hh
    logic signed [11:0] a00, a01, a10, a11, a12, a21, a22;
    assign a00 = 12'(win_r[0][1][k]);
    assign a01 = 12'(win_r[0][2][k]);
    assign a10 = 12'(win_r[1][1][k]);
    assign a11 = 12'(win_r[1][2][k]);
    assign a12 = 12'(mid_eff[k]);
    assign a21 = 12'(win_r[2][2][k]);
    assign a22 = 12'(p_px_r[k]);
    assign hh[k] = 12'(-(a00 <<< 1) - a01 - a10 + a11 + a12 + a21 + (a22 <<< 1));
  end

  // H stage: absolute kernel value
  logic [ACT-1:0][10:0]  h_abs_r;
  logic [COORD_W-1:0]    h_col_r, h_row_r;
  logic                  h_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (adv) begin
      h_v_r <= p_v_r && p_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < ACT; k++) begin
        h_abs_r[k] <= hh[k][11] ? 11'(-hh[k]) : hh[k][10:0];
      end
      h_col_r  <= p_ccol_r;
      h_row_r  <= p_crow_r;
      h_last_r <= p_last_r;
    end
  end

  // square, double, saturate
  for (genvar k = 0; k < NCH; k++) begin : g_sq
    if (k < ACT) begin : g_on
      logic [21:0] sq;
      logic [22:0] s2;
      assign sq = 22'(h_abs_r[k]) * 22'(h_abs_r[k]);
      assign s2 = {sq, 1'b0};
      assign q_data.sum[k] = (s2 > 23'(SAT_LIMIT)) ? SAT_LIMIT : s2[SUM_W-1:0];
    end else begin : g_off
      assign q_data.sum[k] = '0;
    end
  end

  assign q_data.col  = h_col_r;
  assign q_data.row  = h_row_r;
  assign q_data.last = h_last_r;
  assign q_push      = h_v_r && !q_stat.full;

endmodule

### sv/rgbm_queue.sv
// Small FIFO between the front end and the square-root back end.
module rgbm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rgbm_pkg::qent_t   wdata,
  input  logic              pop,
  output rgbm_pkg::qent_t   rdata,
  output rgbm_pkg::qstat_t  stat
);
  import rgbm_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  qent_t           mem_r [Q_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign stat.full  = (cnt_r == (PW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

### sv/rgbm_back.sv
// Back end: bit-per-cycle floor square root and the output register.
module rgbm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rgbm_pkg::qent_t              q_data,
  input  rgbm_pkg::qstat_t             q_stat,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgbm_pkg::NCH-1:0][rgbm_pkg::ROOT_W-1:0] out_mag,
  output logic [rgbm_pkg::COORD_W-1:0] out_col,
  output logic [rgbm_pkg::COORD_W-1:0] out_row,
  output logic                         out_last
);
  import rgbm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                     st_r, st_nxt;
  logic [2:0]                     step_r;
  logic [NCH-1:0][SUM_W-1:0]      n_r;
  logic [NCH-1:0][ROOT_W-1:0]     root_r, root_nxt;
  logic [COORD_W-1:0]             col_r, row_r;
  logic                           last_r;
  logic                           out_valid_r, out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign q_pop     = (st_r == S_IDLE) && !q_stat.empty;

  for (genvar k = 0; k < NCH; k++) begin : g_sqrt
    logic [ROOT_W-1:0] trial;
    logic [SUM_W-1:0]  tsq;
    assign trial       = root_r[k] | (ROOT_W'(1) << step_r);
    assign tsq         = SUM_W'(trial) * SUM_W'(trial);
    assign root_nxt[k] = (tsq <= n_r[k]) ? trial : root_r[k];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (!q_stat.empty) st_nxt = S_RUN;
      S_RUN:   if (step_r == 3'd0) st_nxt = S_DONE;
      S_DONE:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r    <= q_data.sum;
      col_r  <= q_data.col;
      row_r  <= q_data.row;
      last_r <= q_data.last;
      root_r <= '0;
      step_r <= 3'd7;
    end else if (st_r == S_RUN) begin
      root_r <= root_nxt;
      step_r <= step_r - 3'd1;
    end
    if (st_r == S_DONE && out_free) begin
      out_mag  <= root_r;
      out_col  <= col_r;
      out_row  <= row_r;
      out_last <= last_r;
    end
  end

endmodule

### sv/rgb_3x3_dual_kernel_magnitude_unit.sv
// Top level of the RGB 3x3 dual-kernel gradient magnitude unit.
// Path: a result leaves once the pixel right and below its center has been accepted and
//   has passed 2 front stages, the queue, the bit-serial square root and the output register.
// Throughput: one pixel per cycle while the result queue is not full; an interior pixel needs
//   a full run of the shared square-root sequencer, which handles one result at a time and sets the sustained rate.
// Reset (rst_n low, synchronous): counters, window, queue and handshakes clear;
//   width 640, height 480; line stores need no clearing.
module rgb_3x3_dual_kernel_magnitude_unit #(
  parameter int MAX_WIDTH  = rgbm_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = rgbm_pkg::MAX_HEIGHT_D,
  parameter int CHANNELS   = rgbm_pkg::CHANNELS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rgbm_pkg::PIX_W-1:0]    in_pixel_ch0,
  input  logic [rgbm_pkg::PIX_W-1:0]    in_pixel_ch1,
  input  logic [rgbm_pkg::PIX_W-1:0]    in_pixel_ch2,
  input  logic                          in_frame_start,
  // magnitude output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rgbm_pkg::ROOT_W-1:0]   out_mag_ch0,
  output logic [rgbm_pkg::ROOT_W-1:0]   out_mag_ch1,
  output logic [rgbm_pkg::ROOT_W-1:0]   out_mag_ch2,
  output logic [rgbm_pkg::COORD_W-1:0]  out_center_col,
  output logic [rgbm_pkg::COORD_W-1:0]  out_center_row,
  output logic                          out_frame_last,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [rgbm_pkg::REG_W-1:0]    cfg_data
);
  import rgbm_pkg::*;

  logic [REG_W-1:0] width_r, height_r;

  // config is always taken; it must be written only while the datapath is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  pix_t   px;
  qent_t  q_wdata, q_rdata;
  qstat_t q_stat;
  logic   q_push, q_pop;
  logic [NCH-1:0][ROOT_W-1:0] mag;

  assign px[0] = in_pixel_ch0;
  assign px[1] = in_pixel_ch1;
  assign px[2] = in_pixel_ch2;

  // front: window and kernel, stalls only when the queue is full
  rgbm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_px          (px),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  rgbm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: square root and the output register
  rgbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_mag   (mag),
    .out_col   (out_center_col),
    .out_row   (out_center_row),
    .out_last  (out_frame_last)
  );

  assign out_mag_ch0 = mag[0];
  assign out_mag_ch1 = mag[1];
  assign out_mag_ch2 = mag[2];

endmodule

### sv/rgbm_checker.sv
// Port-level checks for the gradient magnitude unit, bound to the top level.
module rgbm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [rgbm_pkg::PIX_W-1:0]    in_pixel_ch0,
  input logic [rgbm_pkg::PIX_W-1:0]    in_pixel_ch1,
  input logic [rgbm_pkg::PIX_W-1:0]    in_pixel_ch2,
  input logic                          in_frame_start,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rgbm_pkg::ROOT_W-1:0]   out_mag_ch0,
  input logic [rgbm_pkg::ROOT_W-1:0]   out_mag_ch1,
  input logic [rgbm_pkg::ROOT_W-1:0]   out_mag_ch2,
  input logic [rgbm_pkg::COORD_W-1:0]  out_center_col,
  input logic [rgbm_pkg::COORD_W-1:0]  out_center_row,
  input logic                          out_frame_last,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // held result must not change under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mag_ch0) &&
      $stable(out_mag_ch1) && $stable(out_mag_ch2) && $stable(out_center_col) &&
      $stable(out_center_row) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // stalled pixel stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_pixel_ch0) &&
      $stable(in_pixel_ch1) && $stable(in_pixel_ch2) && $stable(in_frame_start))
    else $error("pixel changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only interior pixels are reported
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_center_col != '0) && (out_center_row != '0))
    else $error("border pixel reported");

  // register writes land only while no pixel is offered
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !in_valid)
    else $error("register write during pixel transfer");

endmodule

bind rgb_3x3_dual_kernel_magnitude_unit rgbm_checker u_rgbm_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the RGB 3x3 dual-kernel gradient magnitude unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbm_pkg::*;

  // one pixel transfer as the driver sees it
  typedef struct packed {
    logic [PIX_W-1:0] ch0;
    logic [PIX_W-1:0] ch1;
    logic [PIX_W-1:0] ch2;
    logic             fs;
  } pixel_t;

  // one magnitude result
  typedef struct packed {
    logic [ROOT_W-1:0]  m0;
    logic [ROOT_W-1:0]  m1;
    logic [ROOT_W-1:0]  m2;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } mag_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] in_pixel_ch0 = '0, in_pixel_ch1 = '0, in_pixel_ch2 = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROOT_W-1:0] out_mag_ch0, out_mag_ch1, out_mag_ch2;
  logic [COORD_W-1:0] out_center_col, out_center_row;
  logic out_frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_WIDTH;
  logic [REG_W-1:0] cfg_data = '0;

  rgb_3x3_dual_kernel_magnitude_unit uut (.*);

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: line stores, 3x3 window, position, register shadows.
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] shadow_width = WIDTH_RST;
  logic [REG_W-1:0] shadow_height = HEIGHT_RST;
  pix_t upper_line [MAX_WIDTH_D];
  pix_t middle_line [MAX_WIDTH_D];
  pix_t win [3][3];          // [row][col]
  int unsigned pos_col = 0, pos_row = 0;

  pixel_t pending_pixels[$];
  mag_t   expected_mags[$];
  int     error_count = 0;
  int     idle_cycles = 0;

  function automatic int unsigned clamp_dim(logic [REG_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [ROOT_W-1:0] int_root(int unsigned n);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r[ROOT_W-1:0];
  endfunction

  // magnitude of one channel from the current window
  function automatic logic [ROOT_W-1:0] channel_mag(int k);
    int a [3][3];
    int hh, vv;
    int unsigned s;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = win[r][c][k];
    hh = -2*a[0][0] - a[0][1] - a[1][0] + a[1][1] + a[1][2] + a[2][1] + 2*a[2][2];
    vv = -2*a[0][0] - a[1][0] - a[0][1] + a[1][1] + a[2][1] + a[1][2] + 2*a[2][2];
    s = hh*hh + vv*vv;
    if (s > 65025) s = 65025;
    return int_root(s);
  endfunction

  // advance the predictor by one accepted pixel
  task automatic predict_pixel(pixel_t p);
    int unsigned w, h, col, row;
    pix_t px;
    mag_t m;
    w = clamp_dim(shadow_width, MAX_WIDTH_D);
    h = clamp_dim(shadow_height, MAX_HEIGHT_D);
    px[0] = p.ch0;
    px[1] = p.ch1;
    px[2] = p.ch2;
    if (p.fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    col = pos_col;
    row = pos_row;
    if (col >= MAX_WIDTH_D) col = 0;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[col];
    win[1][2] = middle_line[col];
    win[2][2] = px;
    upper_line[col] = middle_line[col];
    middle_line[col] = px;
    if (col >= 2 && row >= 2 && col < w && row < h) begin
      m.m0 = (CHANNELS_D > 0) ? channel_mag(0) : '0;
      m.m1 = (CHANNELS_D > 1) ? channel_mag(1) : '0;
      m.m2 = (CHANNELS_D > 2) ? channel_mag(2) : '0;
      m.col = COORD_W'(col - 1);
      m.row = COORD_W'(row - 1);
      m.last = (col == w - 1 && row == h - 1);
      expected_mags.push_back(m);
    end
    if (col + 1 >= w) begin
      pos_col = 0;
      pos_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      pos_col = col + 1;
      pos_row = row;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;
  bit drive_en = 1'b0;

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_pixel({in_pixel_ch0, in_pixel_ch1, in_pixel_ch2, in_frame_start});
    end
    // only load a new pixel once the current one has transferred
    if (!in_valid || !in_stall) begin
      if (drive_en && pending_pixels.size() > 0 && gap_left == 0) begin
        pixel_t p;
        p = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_pixel_ch0 <= p.ch0;
        in_pixel_ch1 <= p.ch1;
        in_pixel_ch2 <= p.ch2;
        in_frame_start <= p.fs;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver stall pattern.
  // ---------------------------------------------------------------------------
  int stall_phase = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      mag_t got, exp_m;
      got = {out_mag_ch0, out_mag_ch1, out_mag_ch2, out_center_col, out_center_row,
             out_frame_last};
      if (expected_mags.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        exp_m = expected_mags.pop_front();
        if (got !== exp_m) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: result mismatch expected %p actual %p", exp_m, got);
        end
      end
    end
    // stall mode is picked at random from: none, periodic, random
    stall_phase++;
    if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= (stall_phase % 5) < 2;
      default: out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog: cycles without any transfer on the pixel, result or config channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !drive_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) shadow_width = val;
    else shadow_height = val;
  endtask

  // wait until all pixels are in and every expected result has come out
  task automatic wait_quiet();
    drive_en = 1'b1;
    while (pending_pixels.size() > 0 || in_valid || expected_mags.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    drive_en = 1'b0;
  endtask

  function automatic pixel_t rand_pixel(bit fs);
    pixel_t p;
    p.ch0 = $urandom;
    p.ch1 = $urandom;
    p.ch2 = $urandom;
    p.fs = fs;
    return p;
  endfunction

  // queue a complete frame; style selects content: 0 random, 1 extremes, 2 flat
  task automatic queue_frame(int w, int h, int style);
    pixel_t p;
    for (int i = 0; i < w * h; i++) begin
      p = rand_pixel(i == 0);
      if (style == 1) begin
        p.ch0 = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
        p.ch1 = ~p.ch0;
        p.ch2 = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      end else if (style == 2) begin
        p.ch0 = 8'h80;
        p.ch1 = 8'h80;
        p.ch2 = 8'h80;
      end
      pending_pixels.push_back(p);
    end
  endtask

  initial begin
    int w, h, sent;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, then extremes; the saturation case comes from
    // a max corner against zeros.
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    pending_pixels.push_back('{8'h00, 8'h00, 8'h00, 1'b1});
    repeat (3) pending_pixels.push_back('{8'h00, 8'h00, 8'h00, 1'b0});
    pending_pixels.push_back('{8'h00, 8'hFF, 8'h00, 1'b0});
    repeat (3) pending_pixels.push_back('{8'h00, 8'h00, 8'h00, 1'b0});
    pending_pixels.push_back('{8'hFF, 8'h00, 8'hFF, 1'b0});
    // frame wraps without frame_start
    queue_frame(3, 3, 1);
    pending_pixels[9].fs = 1'b0;
    wait_quiet();

    // register values below the minimum clamp to 3
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd1);
    queue_frame(3, 3, 2);
    wait_quiet();

    // height above the maximum clamps; rows keep counting without a wrap
    write_reg(REG_WIDTH, 12'd5);
    write_reg(REG_HEIGHT, 12'hFFF);
    for (int i = 0; i < 5 * 6; i++) pending_pixels.push_back(rand_pixel(i == 0));
    wait_quiet();

    // width above the maximum clamps; a short partial row only
    write_reg(REG_WIDTH, 12'hFFF);
    for (int i = 0; i < 20; i++) pending_pixels.push_back(rand_pixel(i == 0));
    wait_quiet();

    // mid-frame shrink: width lowered while position is past it
    write_reg(REG_WIDTH, 12'd8);
    write_reg(REG_HEIGHT, 12'd6);
    queue_frame(8, 6, 0);
    for (int i = 0; i < 14; i++) pending_pixels.push_back(rand_pixel(i == 0));
    wait_quiet();
    write_reg(REG_WIDTH, 12'd4);
    write_reg(REG_HEIGHT, 12'd3);
    for (int i = 0; i < 30; i++) pending_pixels.push_back(rand_pixel(1'b0));
    wait_quiet();

    // random: mostly full frames with random sizes, some frame_start noise
    sent = 0;
    while (sent < 330) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      write_reg(REG_WIDTH, REG_W'(w));
      write_reg(REG_HEIGHT, REG_W'(h));
      queue_frame(w, h, ($urandom_range(0, 9) == 0) ? 1 : 0);
      // every so often a truncated frame restarted by frame_start
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < $urandom_range(1, 2 * w); i++)
          pending_pixels.push_back(rand_pixel(1'b0));
        queue_frame(w, h, 0);
        sent += w;
      end
      sent += w * h;
      wait_quiet();
    end

    if (error_count == 0 && expected_mags.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
